[rtl/core/bcnec_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bcnec_pkg;

  // Width of the tick counter; phase lengths above its range are clipped
  localparam int TICK_COUNT_BITS = 18;
  // Width of the timing registers and of the configuration data
  localparam int REG_W = 18;
  // Width used when comparing a phase length with the clipped maximum
  localparam int CMP_W = (TICK_COUNT_BITS > REG_W) ? TICK_COUNT_BITS : REG_W;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_KEYS = 7;
  localparam int FRAME_BITS = 32;
  localparam int BITS_LEFT_W = 6;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADDRESS        = 3'd0,
    REG_SECOND_ADDRESS = 3'd1,
    REG_START_MARK     = 3'd2,
    REG_START_SPACE    = 3'd3,
    REG_BIT_MARK       = 3'd4,
    REG_ONE_SPACE      = 3'd5,
    REG_ZERO_SPACE     = 3'd6,
    REG_GAP            = 3'd7
  } reg_idx_t;

  // Input operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_EVENT = 1'b1;

  // Frame sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_START_MARK  = 3'd1,
    PH_START_SPACE = 3'd2,
    PH_BIT_MARK    = 3'd3,
    PH_BIT_SPACE   = 3'd4,
    PH_STOP_MARK   = 3'd5,
    PH_STOP_SPACE  = 3'd6,
    PH_GAP         = 3'd7
  } phase_t;

  // Button word to command byte table
  localparam logic [15:0] KEY_WORDS [NUM_KEYS] = '{
    16'd64975, 16'd64943, 16'd64847, 16'd64783, 16'd64815, 16'd64879, 16'd64911
  };
  localparam logic [7:0] KEY_CMDS [NUM_KEYS] = '{
    8'h90, 8'h50, 8'h61, 8'hC8, 8'h48, 8'hA8, 8'h28
  };

  // Classified request passed from the front to the back
  typedef struct packed {
    logic       is_event;
    logic       hit;
    logic [7:0] cmd;
  } cmd_item_t;

  // One result as delivered on the output queue
  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic indicator;
    logic accepted;
  } result_t;

  // Look a button word up in the table; hit is low for unknown words
  function automatic cmd_item_t key_lookup(input logic [15:0] word);
    cmd_item_t r;
    r = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (!r.hit && word == KEY_WORDS[k]) begin
        r.hit = 1'b1;
        r.cmd = KEY_CMDS[k];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/button_code_to_nec_ir_transmitter_core.sv]
// Button word to NEC-style IR frame transmitter.
// Input queue side: push / full with operation, button_word, previous_word.
//   operation low is one microsecond tick, high is a button event; a request
//   is taken on an edge with push high and full low.
// Result queue side: empty / pop with ir_level, busy_res, indicator, accepted;
//   every request gives exactly one result, taken on an edge with pop high
//   and empty low.
// Configuration: cfg_wr_en, cfg_index, cfg_data write one register per edge,
//   to be used only while the block is idle.
// Path: request queue, sequencer, then the registered result queue.
// Throughput: one request per cycle while the result queue has room; each taken
//   request updates the sequencer between two-entry request and result queues.
// Reset (rst, synchronous): sequencer idle, indicator low, both queues empty,
//   registers back to their defaults.
// When the receiver stalls, the result queue fills, the sequencer holds, and
//   full rises once the request queue holds two entries; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
module button_code_to_nec_ir_transmitter_core (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                push,
  output logic                               full,
  input  wire                                operation,
  input  wire  [15:0]                        button_word,
  input  wire  [15:0]                        previous_word,
  output logic                               empty,
  input  wire                                pop,
  output logic                               ir_level,
  output logic                               busy_res,
  output logic                               indicator,
  output logic                               accepted,
  input  wire                                cfg_wr_en,
  input  wire  [bcnec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [bcnec_pkg::REG_W-1:0]        cfg_data
);
  import bcnec_pkg::*;

  cmd_item_t item;
  logic      item_valid;
  logic      item_take;
  result_t   res;

  bcnec_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .operation     (operation),
    .button_word   (button_word),
    .previous_word (previous_word),
    .item          (item),
    .item_valid    (item_valid),
    .item_take     (item_take)
  );

  bcnec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .res        (res),
    .res_empty  (empty),
    .res_pop    (pop)
  );

  assign ir_level  = res.ir_level;
  assign busy_res  = res.busy_res;
  assign indicator = res.indicator;
  assign accepted  = res.accepted;

endmodule
`default_nettype wire

[rtl/core/bcnec_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module bcnec_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  output logic                 full,
  input  wire                  operation,
  input  wire  [15:0]          button_word,
  input  wire  [15:0]          previous_word,
  output bcnec_pkg::cmd_item_t item,
  output logic                 item_valid,
  input  wire                  item_take
);
  import bcnec_pkg::*;

  cmd_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_item_t  classified;
  cmd_item_t  lk;
  logic       do_push;
  logic       do_pop;

  // Classify: tick, or event with matching words and a known code
  always_comb begin
    lk = key_lookup(button_word);
    classified.is_event = (operation == OP_EVENT);
    classified.hit      = (operation == OP_EVENT) && (button_word == previous_word) && lk.hit;
    classified.cmd      = lk.cmd;
  end

  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;

  // Two-entry request queue
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/bcnec_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module bcnec_back (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_wr_en,
  input  wire  [bcnec_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [bcnec_pkg::REG_W-1:0]          cfg_data,
  input  wire  bcnec_pkg::cmd_item_t           item,
  input  wire                                  item_valid,
  output logic                                 item_take,
  output bcnec_pkg::result_t                   res,
  output logic                                 res_empty,
  input  wire                                  res_pop
);
  import bcnec_pkg::*;

  localparam logic [TICK_COUNT_BITS-1:0] CNT_MAX = '1;

  // Configuration registers
  logic [7:0]       address_byte;
  logic [7:0]       second_address_byte;
  logic [REG_W-1:0] start_mark_ticks;
  logic [REG_W-1:0] start_space_ticks;
  logic [REG_W-1:0] bit_mark_ticks;
  logic [REG_W-1:0] one_space_ticks;
  logic [REG_W-1:0] zero_space_ticks;
  logic [REG_W-1:0] gap_ticks;

  // Sequencer state
  phase_t                     phase, phase_next;
  logic [BITS_LEFT_W-1:0]     bits_left, bits_left_next;
  logic [TICK_COUNT_BITS-1:0] tick_count, tick_count_next;
  logic [FRAME_BITS-1:0]      frame_shift, frame_shift_next;
  logic                       indicator_level, indicator_level_next;

  // Result queue
  result_t    rq [2];
  logic       rq_wr;
  logic       rq_rd;
  logic [1:0] rq_count;
  logic       rq_pop;
  result_t    res_new;

  logic [REG_W-1:0]       len;
  logic [CMP_W-1:0]       len_c;
  logic [CMP_W:0]         next_cnt;
  logic                   phase_done;
  logic [BITS_LEFT_W-1:0] bits_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_byte        <= 8'd97;
      second_address_byte <= 8'd78;
      start_mark_ticks    <= REG_W'(8950);
      start_space_ticks   <= REG_W'(4450);
      bit_mark_ticks      <= REG_W'(560);
      one_space_ticks     <= REG_W'(1625);
      zero_space_ticks    <= REG_W'(550);
      gap_ticks           <= REG_W'(250000);
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ADDRESS:        address_byte        <= cfg_data[7:0];
        REG_SECOND_ADDRESS: second_address_byte <= cfg_data[7:0];
        REG_START_MARK:     start_mark_ticks    <= cfg_data;
        REG_START_SPACE:    start_space_ticks   <= cfg_data;
        REG_BIT_MARK:       bit_mark_ticks      <= cfg_data;
        REG_ONE_SPACE:      one_space_ticks     <= cfg_data;
        REG_ZERO_SPACE:     zero_space_ticks    <= cfg_data;
        REG_GAP:            gap_ticks           <= cfg_data;
        default:            address_byte        <= address_byte;
      endcase
    end
  end

  // Take a request whenever the result queue has room (or is draining)
  assign rq_pop    = res_pop && (rq_count != 2'd0);
  assign item_take = item_valid && ((rq_count != 2'd2) || rq_pop);

  // Length of the current phase, clipped to the counter range
  always_comb begin
    unique case (phase)
      PH_START_MARK:  len = start_mark_ticks;
      PH_START_SPACE: len = start_space_ticks;
      PH_BIT_MARK:    len = bit_mark_ticks;
      PH_BIT_SPACE:   len = frame_shift[FRAME_BITS-1] ? one_space_ticks : zero_space_ticks;
      PH_STOP_MARK:   len = bit_mark_ticks;
      PH_STOP_SPACE:  len = one_space_ticks;
      PH_GAP:         len = gap_ticks;
      default:        len = REG_W'(1);
    endcase
    len_c      = (CMP_W'(len) > CMP_W'(CNT_MAX)) ? CMP_W'(CNT_MAX) : CMP_W'(len);
    next_cnt   = (CMP_W+1)'(tick_count) + (CMP_W+1)'(1);
    phase_done = (next_cnt >= {1'b0, len_c});
    bits_dec   = bits_left - BITS_LEFT_W'(1);
  end

  // Next state and result for the request being taken
  always_comb begin
    phase_next           = phase;
    bits_left_next       = bits_left;
    tick_count_next      = tick_count;
    frame_shift_next     = frame_shift;
    indicator_level_next = indicator_level;
    res_new.accepted     = 1'b0;
    if (item_take) begin
      if (!item.is_event) begin
        if (phase != PH_IDLE) begin
          if (phase_done) begin
            tick_count_next = '0;
            unique case (phase)
              PH_START_MARK:  phase_next = PH_START_SPACE;
              PH_START_SPACE: phase_next = PH_BIT_MARK;
              PH_BIT_MARK:    phase_next = PH_BIT_SPACE;
              PH_BIT_SPACE: begin
                frame_shift_next = {frame_shift[FRAME_BITS-2:0], 1'b0};
                bits_left_next   = bits_dec;
                phase_next       = (bits_dec == '0) ? PH_STOP_MARK : PH_BIT_MARK;
              end
              PH_STOP_MARK:   phase_next = PH_STOP_SPACE;
              PH_STOP_SPACE:  phase_next = PH_GAP;
              default:        phase_next = PH_IDLE;
            endcase
          end else begin
            tick_count_next = next_cnt[TICK_COUNT_BITS-1:0];
          end
        end
      end else if (phase == PH_IDLE && item.hit) begin
        frame_shift_next     = {address_byte, second_address_byte, item.cmd, ~item.cmd};
        bits_left_next       = BITS_LEFT_W'(FRAME_BITS);
        tick_count_next      = '0;
        phase_next           = PH_START_MARK;
        indicator_level_next = ~indicator_level;
        res_new.accepted     = 1'b1;
      end
    end
    res_new.ir_level  = (phase_next == PH_START_MARK) || (phase_next == PH_BIT_MARK) ||
                        (phase_next == PH_STOP_MARK);
    res_new.busy_res  = (phase_next != PH_IDLE);
    res_new.indicator = indicator_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bits_left       <= '0;
      tick_count      <= '0;
      frame_shift     <= '0;
      indicator_level <= 1'b0;
    end else begin
      phase           <= phase_next;
      bits_left       <= bits_left_next;
      tick_count      <= tick_count_next;
      frame_shift     <= frame_shift_next;
      indicator_level <= indicator_level_next;
    end
  end

  // Two-entry result queue
  always_ff @(posedge clk) begin
    if (item_take) begin
      rq[rq_wr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr    <= 1'b0;
      rq_rd    <= 1'b0;
      rq_count <= 2'd0;
    end else begin
      if (item_take) rq_wr <= ~rq_wr;
      if (rq_pop)    rq_rd <= ~rq_rd;
      unique case ({item_take, rq_pop})
        2'b10:   rq_count <= rq_count + 2'd1;
        2'b01:   rq_count <= rq_count - 2'd1;
        default: rq_count <= rq_count;
      endcase
    end
  end

  assign res       = rq[rq_rd];
  assign res_empty = (rq_count == 2'd0);

endmodule
`default_nettype wire

[tb/sv/tb_button_code_to_nec_ir_transmitter_core.sv]
`timescale 1ns / 1ps

import bcnec_pkg::*;

// Mirrors the IR frame sequencer and queues the outputs each request must give
class ir_frame_scoreboard;
  logic [15:0]                button_words [NUM_KEYS];
  logic [7:0]                 button_cmds [NUM_KEYS];
  logic [7:0]                 addr_first;
  logic [7:0]                 addr_second;
  logic [REG_W-1:0]           start_mark;
  logic [REG_W-1:0]           start_space;
  logic [REG_W-1:0]           bit_mark;
  logic [REG_W-1:0]           one_space;
  logic [REG_W-1:0]           zero_space;
  logic [REG_W-1:0]           gap_len;
  phase_t                     seq_phase;
  logic [BITS_LEFT_W-1:0]     bits_left;
  logic [TICK_COUNT_BITS-1:0] tick_count;
  logic [FRAME_BITS-1:0]      frame_shift;
  logic                       ind_level;
  result_t                    expected_q [$];
  int unsigned                mismatch_count;

  function new();
    button_words = '{16'd64975, 16'd64943, 16'd64847, 16'd64783,
                     16'd64815, 16'd64879, 16'd64911};
    button_cmds  = '{8'h90, 8'h50, 8'h61, 8'hC8, 8'h48, 8'hA8, 8'h28};
    addr_first     = 8'd97;
    addr_second    = 8'd78;
    start_mark     = REG_W'(8950);
    start_space    = REG_W'(4450);
    bit_mark       = REG_W'(560);
    one_space      = REG_W'(1625);
    zero_space     = REG_W'(550);
    gap_len        = REG_W'(250000);
    seq_phase      = PH_IDLE;
    bits_left      = '0;
    tick_count     = '0;
    frame_shift    = '0;
    ind_level      = 1'b0;
    mismatch_count = 0;
  endfunction

  function void write_reg(reg_idx_t idx, logic [REG_W-1:0] d);
    case (idx)
      REG_ADDRESS:        addr_first = d[7:0];
      REG_SECOND_ADDRESS: addr_second = d[7:0];
      REG_START_MARK:     start_mark = d;
      REG_START_SPACE:    start_space = d;
      REG_BIT_MARK:       bit_mark = d;
      REG_ONE_SPACE:      one_space = d;
      REG_ZERO_SPACE:     zero_space = d;
      REG_GAP:            gap_len = d;
      default: ;
    endcase
  endfunction

  function bit is_idle();
    return seq_phase == PH_IDLE;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Length of the running phase; a bit space depends on the bit being sent
  function logic [REG_W-1:0] phase_ticks();
    case (seq_phase)
      PH_START_MARK:              return start_mark;
      PH_START_SPACE:             return start_space;
      PH_BIT_MARK, PH_STOP_MARK:  return bit_mark;
      PH_BIT_SPACE:               return frame_shift[FRAME_BITS-1] ? one_space : zero_space;
      PH_STOP_SPACE:              return one_space;
      PH_GAP:                     return gap_len;
      default:                    return REG_W'(1);
    endcase
  endfunction

  function void end_phase();
    case (seq_phase)
      PH_START_MARK:  seq_phase = PH_START_SPACE;
      PH_START_SPACE: seq_phase = PH_BIT_MARK;
      PH_BIT_MARK:    seq_phase = PH_BIT_SPACE;
      PH_BIT_SPACE: begin
        frame_shift = frame_shift << 1;
        bits_left   = bits_left - 1'b1;
        seq_phase   = (bits_left == 0) ? PH_STOP_MARK : PH_BIT_MARK;
      end
      PH_STOP_MARK:   seq_phase = PH_STOP_SPACE;
      PH_STOP_SPACE:  seq_phase = PH_GAP;
      default:        seq_phase = PH_IDLE;
    endcase
    tick_count = '0;
  endfunction

  // Advance the model by one accepted request and queue the outputs it gives
  function void note_request(logic op, logic [15:0] word, logic [15:0] prev);
    int unsigned len;
    int unsigned nxt;
    int unsigned cmax;
    logic        started;
    result_t     r;
    started = 1'b0;
    cmax = (32'd1 << TICK_COUNT_BITS) - 1;
    if (op == OP_TICK) begin
      // a tick while idle changes nothing
      if (seq_phase != PH_IDLE) begin
        len = phase_ticks();
        nxt = tick_count + 1;
        if (len > cmax)
          len = cmax;
        // a zero length ends on the first tick, just like a length of one
        if (nxt >= len)
          end_phase();
        else
          tick_count = TICK_COUNT_BITS'(nxt);
      end
    end else if (seq_phase == PH_IDLE && word == prev) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (!started && button_words[k] == word) begin
          frame_shift = {addr_first, addr_second, button_cmds[k], ~button_cmds[k]};
          bits_left   = BITS_LEFT_W'(FRAME_BITS);
          tick_count  = '0;
          seq_phase   = PH_START_MARK;
          ind_level   = ~ind_level;
          started     = 1'b1;
        end
      end
    end
    r.ir_level  = (seq_phase == PH_START_MARK || seq_phase == PH_BIT_MARK ||
                   seq_phase == PH_STOP_MARK);
    r.busy_res  = (seq_phase != PH_IDLE);
    r.indicator = ind_level;
    r.accepted  = started;
    expected_q.push_back(r);
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected result ir=%b busy=%b ind=%b acc=%b", $time,
                 got.ir_level, got.busy_res, got.indicator, got.accepted);
      return;
    end
    want = expected_q.pop_front();
    if (got.ir_level !== want.ir_level || got.busy_res !== want.busy_res ||
        got.indicator !== want.indicator || got.accepted !== want.accepted) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: mismatch, expected ir=%b busy=%b ind=%b acc=%b, got ir=%b busy=%b ind=%b acc=%b",
                 $time, want.ir_level, want.busy_res, want.indicator, want.accepted,
                 got.ir_level, got.busy_res, got.indicator, got.accepted);
    end
  endfunction
endclass

module tb_button_code_to_nec_ir_transmitter_core;

  typedef struct {
    logic [REG_W-1:0] addr_first;
    logic [REG_W-1:0] addr_second;
    logic [REG_W-1:0] start_mark;
    logic [REG_W-1:0] start_space;
    logic [REG_W-1:0] bit_mark;
    logic [REG_W-1:0] one_space;
    logic [REG_W-1:0] zero_space;
    logic [REG_W-1:0] gap_len;
  } reg_set_t;

  typedef enum logic [1:0] {POP_ALWAYS, POP_TWO_OF_THREE, POP_COIN, POP_RARE} pop_mode_t;

  localparam logic [REG_W-1:0] TICKS_MAX = '1;

  logic             clk;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             operation = OP_TICK;
  logic [15:0]      button_word = '0;
  logic [15:0]      previous_word = '0;
  logic             pop = 1'b0;
  logic             cfg_wr_en = 1'b0;
  reg_idx_t         cfg_index = REG_ADDRESS;
  logic [REG_W-1:0] cfg_data = '0;
  wire              full;
  wire              empty;
  wire              ir_level;
  wire              busy_res;
  wire              indicator;
  wire              accepted;

  ir_frame_scoreboard sb;
  int unsigned        burst_left = 0;
  int unsigned        next_key = 0;
  int unsigned        stall_cnt = 0;
  pop_mode_t          pop_mode = POP_ALWAYS;

  button_code_to_nec_ir_transmitter_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .operation     (operation),
    .button_word   (button_word),
    .previous_word (previous_word),
    .empty         (empty),
    .pop           (pop),
    .ir_level      (ir_level),
    .busy_res      (busy_res),
    .indicator     (indicator),
    .accepted      (accepted),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("button_code_to_nec_ir_transmitter_core verification failed");
    $finish;
  end

  // Result side: check every popped result, stall on a changing pattern
  always @(posedge clk) begin
    if (pop && !empty)
      sb.check_result(result_t'{ir_level, busy_res, indicator, accepted});
    stall_cnt++;
    if (stall_cnt % 64 == 0)
      pop_mode = pop_mode_t'($urandom_range(0, 3));
    if (rst) begin
      pop <= 1'b0;
    end else begin
      case (pop_mode)
        POP_ALWAYS:       pop <= 1'b1;
        POP_TWO_OF_THREE: pop <= (stall_cnt % 3 != 0);
        POP_COIN:         pop <= 1'($urandom_range(0, 1));
        default:          pop <= (stall_cnt % 16 == 0);
      endcase
    end
  end

  // Request side: bursts of random length with random gaps in between
  task automatic send_request(input logic op, input logic [15:0] word,
                              input logic [15:0] prev);
    int unsigned idle_cycles;
    if (burst_left == 0) begin
      burst_left  = $urandom_range(1, 40);
      idle_cycles = $urandom_range(0, 6);
      if (idle_cycles != 0) begin
        push <= 1'b0;
        repeat (idle_cycles) @(posedge clk);
      end
    end
    burst_left--;
    push          <= 1'b1;
    operation     <= op;
    button_word   <= word;
    previous_word <= prev;
    do @(posedge clk); while (full);
    sb.note_request(op, word, prev);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [REG_W-1:0] d);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic load_regs(input reg_set_t s, input bit with_addr);
    if (with_addr) begin
      cfg_write(REG_ADDRESS, s.addr_first);
      cfg_write(REG_SECOND_ADDRESS, s.addr_second);
    end
    cfg_write(REG_START_MARK, s.start_mark);
    cfg_write(REG_START_SPACE, s.start_space);
    cfg_write(REG_BIT_MARK, s.bit_mark);
    cfg_write(REG_ONE_SPACE, s.one_space);
    cfg_write(REG_ZERO_SPACE, s.zero_space);
    cfg_write(REG_GAP, s.gap_len);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic reg_set_t random_regs(int unsigned top);
    reg_set_t s;
    s.addr_first  = REG_W'($urandom);
    s.addr_second = REG_W'($urandom);
    s.start_mark  = REG_W'($urandom_range(0, top));
    s.start_space = REG_W'($urandom_range(0, top));
    s.bit_mark    = REG_W'($urandom_range(0, top));
    s.one_space   = REG_W'($urandom_range(0, top));
    s.zero_space  = REG_W'($urandom_range(0, top));
    s.gap_len     = REG_W'($urandom_range(0, top));
    return s;
  endfunction

  // Tick the frame out, then let the result queue drain before a register write
  task automatic settle();
    logic [15:0] w;
    while (!sb.is_idle()) begin
      w = 16'($urandom);
      send_request(OP_TICK, w, ~w);
    end
    push <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // Random requests until n of them did something: mostly valid presses when
  // idle and ticks when busy, with mismatched, unknown and dropped presses mixed in
  task automatic random_run(input int unsigned n);
    int unsigned done;
    int unsigned roll;
    int unsigned k;
    logic [15:0] w;
    logic [15:0] p;
    bit          was_idle;
    logic        op;
    done = 0;
    while (done < n) begin
      roll     = $urandom_range(0, 99);
      k        = $urandom_range(0, NUM_KEYS - 1);
      w        = 16'($urandom);
      p        = 16'($urandom);
      was_idle = sb.is_idle();
      op       = OP_EVENT;
      if (was_idle) begin
        if (roll < 55) begin
          send_request(OP_EVENT, sb.button_words[next_key], sb.button_words[next_key]);
          next_key = (next_key + 1) % NUM_KEYS;
        end else if (roll < 70) begin
          // known word, previous word one bit off
          w = sb.button_words[k];
          send_request(OP_EVENT, w, w ^ (16'd1 << $urandom_range(0, 15)));
        end else if (roll < 80) begin
          send_request(OP_EVENT, w, roll[0] ? w : p);
        end else begin
          op = OP_TICK;
          send_request(OP_TICK, w, p);
        end
      end else if (roll < 88) begin
        op = OP_TICK;
        send_request(OP_TICK, w, p);
      end else if (roll < 95) begin
        send_request(OP_EVENT, sb.button_words[k], sb.button_words[k]);
      end else begin
        send_request(OP_EVENT, w, p);
      end
      if (was_idle ? !sb.is_idle() : (op == OP_TICK))
        done++;
    end
  endtask

  initial begin
    reg_set_t regs;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // short timings, address bytes left at their reset values
    regs = '{'0, '0, REG_W'(2), REG_W'(1), REG_W'(1), REG_W'(2), REG_W'(1), REG_W'(3)};
    load_regs(regs, 1'b0);

    // idle ticks, unknown words at both extremes, mismatched pairs
    send_request(OP_TICK, 16'h0000, 16'h0000);
    send_request(OP_TICK, 16'hFFFF, 16'hFFFF);
    send_request(OP_EVENT, 16'h0000, 16'h0000);
    send_request(OP_EVENT, 16'hFFFF, 16'hFFFF);
    send_request(OP_EVENT, sb.button_words[0], sb.button_words[1]);
    send_request(OP_EVENT, sb.button_words[3], sb.button_words[3] ^ 16'h0001);
    // valid press, then presses while busy are dropped
    send_request(OP_EVENT, sb.button_words[2], sb.button_words[2]);
    send_request(OP_EVENT, sb.button_words[3], sb.button_words[3]);
    repeat (3) send_request(OP_TICK, 16'h5A5A, 16'hA5A5);
    send_request(OP_EVENT, sb.button_words[5], sb.button_words[6]);
    settle();
    send_request(OP_EVENT, sb.button_words[4], sb.button_words[4]);
    random_run(40);
    settle();

    // every timing register at zero, address bytes at opposite extremes
    regs = '{REG_W'(8'h00), REG_W'(8'hFF), '0, '0, '0, '0, '0, '0};
    load_regs(regs, 1'b1);
    random_run(40);
    settle();

    regs = '{REG_W'(8'hFF), REG_W'(8'h00), REG_W'(1), REG_W'(1), REG_W'(1), REG_W'(1),
             REG_W'(1), REG_W'(1)};
    load_regs(regs, 1'b1);
    random_run(40);
    settle();

    load_regs(random_regs(3), 1'b1);
    random_run(40);
    settle();

    // longest timings: the frame is still in its start mark at the end
    regs = random_regs(0);
    regs.start_mark  = TICKS_MAX;
    regs.start_space = TICKS_MAX;
    regs.bit_mark    = TICKS_MAX;
    regs.one_space   = TICKS_MAX;
    regs.zero_space  = TICKS_MAX;
    regs.gap_len     = TICKS_MAX;
    load_regs(regs, 1'b1);
    send_request(OP_EVENT, sb.button_words[next_key], sb.button_words[next_key]);
    random_run(25);

    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0)
      $display("button_code_to_nec_ir_transmitter_core verification clean");
    else
      $display("button_code_to_nec_ir_transmitter_core verification failed");
    $finish;
  end

endmodule
